[rtl/utf16_utf32_to_utf8_encoder_macros.svh]
`ifndef UTF16_UTF32_TO_UTF8_ENCODER_MACROS_SVH
`define UTF16_UTF32_TO_UTF8_ENCODER_MACROS_SVH

// Same-cycle implication, switched off while reset is held.
`define UTFENC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, switched off while reset is held.
`define UTFENC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that also runs through reset.
`define UTFENC_ASSERT_NEXT_ALL(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/utfenc_pkg.sv]
`timescale 1ns / 1ps

package utfenc_pkg;

    localparam int unsigned QUEUE_DEPTH_DEF = 4;

    localparam int unsigned CP_W      = 26;
    localparam int unsigned LEN_W     = 3;
    localparam int unsigned CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_UNIT_IS_32BIT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_STRIP_BOM     = 1'b1;

    localparam logic [15:0] BOM_UNIT      = 16'hFEFF;
    localparam logic [5:0]  HIGH_SURR_TAG = 6'b110110;
    localparam logic [5:0]  LOW_SURR_TAG  = 6'b110111;
    localparam logic [20:0] SUPP_BASE     = 21'h10000;

    localparam logic [LEN_W-1:0] LEN_SURR   = 3'd3;
    localparam logic [LEN_W-1:0] LEN_JOINED = 3'd4;

    // One queue entry: an optional lone high surrogate (point a) followed by
    // an optional code point (point b). flag is the sticky non-ASCII state
    // that holds for every byte of the entry.
    typedef struct packed {
        logic             a_valid;
        logic [9:0]       a_bits;
        logic             b_valid;
        logic [CP_W-1:0]  b_cp;
        logic [LEN_W-1:0] b_len;
        logic             flag;
    } t_entry;

endpackage

[rtl/utfenc_front.sv]
`timescale 1ns / 1ps

module utfenc_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [utfenc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic                            i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [31:0]                     i_code_unit,
    input  logic                            i_first_of_text,
    input  logic                            i_last_of_text,
    input  logic                            i_full,
    output logic                            o_push,
    output utfenc_pkg::t_entry              o_entry
);
    import utfenc_pkg::*;

    logic       r_unit_is_32bit;
    logic       r_strip_bom;
    logic       r_held_valid;
    logic [9:0] r_held_bits;
    logic       r_flag;

    logic       n_held_valid;
    logic [9:0] n_held_bits;

    logic        accept;
    logic [15:0] u;
    logic        held_v0;
    logic        flag0;
    logic        u_low;
    logic        u_high;
    logic        first_bom;
    logic        b_non_ascii;
    logic [20:0] joined;
    t_entry      entry;

    function automatic logic [LEN_W-1:0] len_of(input logic [31:0] w);
        logic [LEN_W-1:0] l;
        if (|w[31:21]) begin
            l = 3'd5;
        end else if (|w[20:16]) begin
            l = 3'd4;
        end else if (|w[15:11]) begin
            l = 3'd3;
        end else if (|w[10:7]) begin
            l = 3'd2;
        end else begin
            l = 3'd1;
        end
        return l;
    endfunction

    assign o_in_stall = i_full;
    assign accept     = i_in_valid & ~i_full;

    always_comb begin
        u            = i_code_unit[15:0];
        held_v0      = r_held_valid & ~i_first_of_text;
        flag0        = r_flag & ~i_first_of_text;
        u_low        = (u[15:10] == LOW_SURR_TAG);
        u_high       = (u[15:10] == HIGH_SURR_TAG);
        joined       = SUPP_BASE + {1'b0, r_held_bits, u[9:0]};
        entry        = '0;
        b_non_ascii  = 1'b0;
        n_held_valid = held_v0;
        n_held_bits  = r_held_bits;

        if (r_unit_is_32bit) begin
            // no surrogate joining on full-width code points
            n_held_valid  = 1'b0;
            first_bom     = i_first_of_text & r_strip_bom & (i_code_unit == {16'h0, BOM_UNIT});
            entry.b_valid = ~first_bom;
            entry.b_cp    = i_code_unit[CP_W-1:0];
            entry.b_len   = len_of(i_code_unit);
            b_non_ascii   = |i_code_unit[31:7];
        end else begin
            first_bom = i_first_of_text & r_strip_bom & (u == BOM_UNIT);
            if (!first_bom) begin
                if (held_v0) begin
                    n_held_valid = 1'b0;
                    if (u_low) begin
                        entry.b_valid = 1'b1;
                        entry.b_cp    = {5'b0, joined};
                        entry.b_len   = LEN_JOINED;
                        b_non_ascii   = 1'b1;
                    end else begin
                        entry.a_valid = 1'b1;
                        entry.a_bits  = r_held_bits;
                    end
                end
                if (!(held_v0 && u_low)) begin
                    if (u_high && !i_last_of_text) begin
                        n_held_valid = 1'b1;
                        n_held_bits  = u[9:0];
                    end else begin
                        entry.b_valid = 1'b1;
                        entry.b_cp    = {10'b0, u};
                        entry.b_len   = len_of({16'b0, u});
                        b_non_ascii   = |u[15:7];
                    end
                end
            end
        end

        entry.flag = flag0 | entry.a_valid | (entry.b_valid & b_non_ascii);
    end

    assign o_push  = accept & (entry.a_valid | entry.b_valid);
    assign o_entry = entry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_unit_is_32bit <= 1'b0;
            r_strip_bom     <= 1'b1;
            r_held_valid    <= 1'b0;
            r_held_bits     <= '0;
            r_flag          <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_UNIT_IS_32BIT: r_unit_is_32bit <= i_cfg_data;
                    REG_STRIP_BOM:     r_strip_bom     <= i_cfg_data;
                    default: ;
                endcase
            end
            if (accept) begin
                r_held_valid <= n_held_valid;
                r_held_bits  <= n_held_bits;
                r_flag       <= entry.flag;
            end
        end
    end

endmodule

[rtl/utfenc_queue.sv]
`timescale 1ns / 1ps

module utfenc_queue #(
    parameter int unsigned WIDTH = 1,
    parameter int unsigned DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data,
    input  logic             i_pop
);
    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    logic do_push;
    logic do_pop;

    function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push & ~o_full;
    assign do_pop  = i_pop & o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= ptr_next(r_wr_ptr);
            end
            if (do_pop) begin
                r_rd_ptr <= ptr_next(r_rd_ptr);
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: ;
            endcase
        end
    end

endmodule

[rtl/utfenc_back.sv]
`timescale 1ns / 1ps

module utfenc_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_head_valid,
    input  utfenc_pkg::t_entry i_head,
    output logic               o_pop,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [7:0]         o_out_byte,
    output logic               o_last_byte,
    output logic               o_non_ascii_seen
);
    import utfenc_pkg::*;

    logic             r_out_valid;
    logic [7:0]       r_out_byte;
    logic             r_out_last;
    logic             r_out_flag;
    logic [LEN_W-1:0] r_idx;
    logic             r_phase_b;

    logic             advance;
    logic             eff_b;
    logic [CP_W-1:0]  cp;
    logic [LEN_W-1:0] len;
    logic             point_end;
    logic             item_end;
    logic [7:0]       cur_byte;

    function automatic logic [7:0] enc_byte(input logic [CP_W-1:0] c,
                                            input logic [LEN_W-1:0] l,
                                            input logic [LEN_W-1:0] k);
        logic [7:0]       b;
        logic [LEN_W-1:0] sh;
        sh = l - k - 1'b1;
        if (k == '0) begin
            unique case (l)
                3'd1:    b = {1'b0, c[6:0]};
                3'd2:    b = {3'b110, c[10:6]};
                3'd3:    b = {4'b1110, c[15:12]};
                3'd4:    b = {5'b11110, c[20:18]};
                default: b = {6'b111110, c[25:24]};
            endcase
        end else begin
            // continuation byte: six bits from the top down
            unique case (sh)
                3'd0:    b = {2'b10, c[5:0]};
                3'd1:    b = {2'b10, c[11:6]};
                3'd2:    b = {2'b10, c[17:12]};
                default: b = {2'b10, c[23:18]};
            endcase
        end
        return b;
    endfunction

    always_comb begin
        eff_b     = r_phase_b | ~i_head.a_valid;
        cp        = eff_b ? i_head.b_cp : {10'b0, HIGH_SURR_TAG, i_head.a_bits};
        len       = eff_b ? i_head.b_len : LEN_SURR;
        point_end = (r_idx == len - 1'b1);
        item_end  = point_end & (eff_b | ~i_head.b_valid);
        cur_byte  = enc_byte(cp, len, r_idx);
    end

    assign advance = ~r_out_valid | ~i_out_stall;
    assign o_pop   = advance & i_head_valid & item_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_idx       <= '0;
            r_phase_b   <= 1'b0;
        end else if (advance) begin
            r_out_valid <= i_head_valid;
            if (i_head_valid) begin
                if (point_end) begin
                    r_idx     <= '0;
                    r_phase_b <= ~item_end;
                end else begin
                    r_idx <= r_idx + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && i_head_valid) begin
            r_out_byte <= cur_byte;
            r_out_last <= item_end;
            r_out_flag <= i_head.flag;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_out_byte       = r_out_byte;
    assign o_last_byte      = r_out_last;
    assign o_non_ascii_seen = r_out_flag;

endmodule

[rtl/utf16_utf32_to_utf8_encoder.sv]
`timescale 1ns / 1ps

// UTF-16 / UTF-32 to UTF-8 encoder.
// Input channel (i_in_valid / o_in_stall): one code unit per item with
// first/last-of-text marks. Output channel (o_out_valid / i_out_stall): one
// UTF-8 byte per item, o_last_byte on the final byte caused by an input item,
// o_non_ascii_seen the sticky non-ASCII flag of the current text.
// Config: i_cfg_we writes register i_cfg_index (0 unit width, 1 BOM strip)
// with i_cfg_data; write only while the block is idle.
// The front classifies each unit in its accept cycle (surrogate joining, BOM
// drop) and writes at most one entry to a QUEUE_DEPTH-deep queue; the back turns an
// entry into 1 to 6 bytes, one per cycle while i_out_stall is low, through an output register.
// The first byte of a unit passes through the queue and then the output register.
// Throughput: set by the back's one-byte-per-cycle output while i_out_stall is
// low; a unit produces 1 to 6 bytes, and units that produce no byte (held high
// surrogate, dropped BOM) push no queue entry.
// Stall: the output register holds while i_out_stall is high; the front keeps
// accepting until the queue is full, then raises o_in_stall.
// Reset (synchronous, active low): registers back to unit_is_32bit = 0,
// strip_bom = 1, queue empty, no held surrogate, flag clear.
module utf16_utf32_to_utf8_encoder #(
    parameter int unsigned QUEUE_DEPTH = utfenc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [utfenc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic                            i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [31:0]                     i_code_unit,
    input  logic                            i_first_of_text,
    input  logic                            i_last_of_text,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [7:0]                      o_out_byte,
    output logic                            o_last_byte,
    output logic                            o_non_ascii_seen
);
    import utfenc_pkg::*;

    logic   push;
    logic   full;
    logic   head_valid;
    logic   pop;
    t_entry push_entry;
    t_entry head_entry;

    utfenc_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_code_unit     (i_code_unit),
        .i_first_of_text (i_first_of_text),
        .i_last_of_text  (i_last_of_text),
        .i_full          (full),
        .o_push          (push),
        .o_entry         (push_entry)
    );

    utfenc_queue #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_entry),
        .o_full  (full),
        .o_valid (head_valid),
        .o_data  (head_entry),
        .i_pop   (pop)
    );

    utfenc_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_head_valid     (head_valid),
        .i_head           (head_entry),
        .o_pop            (pop),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_out_byte       (o_out_byte),
        .o_last_byte      (o_last_byte),
        .o_non_ascii_seen (o_non_ascii_seen)
    );

endmodule

[rtl/utfenc_checker.sv]
`timescale 1ns / 1ps
`include "utf16_utf32_to_utf8_encoder_macros.svh"

module utfenc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [7:0] o_out_byte,
    input logic       o_last_byte,
    input logic       o_non_ascii_seen
);

    // a stalled byte stays put
    `UTFENC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_byte) && $stable(o_last_byte) && $stable(o_non_ascii_seen), "output changed under stall")

    // ASCII bytes are always single-byte points and close their item
    `UTFENC_ASSERT_NOW(a_ascii_last, i_clk, i_rst_n, o_out_valid && !o_out_byte[7], o_last_byte, "ASCII byte not marked last")

    // any byte with the top bit set belongs to a non-ASCII point
    `UTFENC_ASSERT_NOW(a_flag_set, i_clk, i_rst_n, o_out_valid && o_out_byte[7], o_non_ascii_seen, "non-ASCII byte without flag")

    `UTFENC_ASSERT_NEXT_ALL(a_reset_idle, i_clk, !i_rst_n, !o_out_valid, "output valid right after reset")

endmodule

bind utf16_utf32_to_utf8_encoder utfenc_checker u_checker (.*);

[sim/tb_utf16_utf32_to_utf8_encoder.sv]
`timescale 1ns / 1ps

module tb_utf16_utf32_to_utf8_encoder;
    import utfenc_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned RANDOM_UNITS = 320;
    localparam int unsigned SETTLE_CYCLES = 8;

    typedef struct packed {
        logic [31:0] cu;
        logic        first;
        logic        last;
    } unit_item_t;

    typedef struct packed {
        logic [7:0] value;
        logic       last;
        logic       flag;
    } utf8_byte_t;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic                 i_cfg_data = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    logic [31:0]          i_code_unit = '0;
    logic                 i_first_of_text = 1'b0;
    logic                 i_last_of_text = 1'b0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic [7:0]           o_out_byte;
    logic                 o_last_byte;
    logic                 o_non_ascii_seen;

    // encoder state mirror
    logic       cfg_wide = 1'b0;
    logic       cfg_strip = 1'b1;
    logic [9:0] held_bits = '0;
    logic       held_valid = 1'b0;
    logic       non_ascii = 1'b0;

    unit_item_t units_to_send[$];
    utf8_byte_t step_bytes[$];
    utf8_byte_t utf8_due[$];

    logic        unit_accepted = 1'b0;
    logic        byte_accepted = 1'b0;
    logic        sending = 1'b0;
    logic        calm = 1'b0;
    int unsigned gap_left = 0;
    int unsigned hold_left = 0;
    int unsigned cycles = 0;
    int unsigned errors = 0;
    int unsigned queued = 0;
    int unsigned units_done = 0;
    int unsigned bytes_done = 0;
    int unsigned phases = 0;

    utf16_utf32_to_utf8_encoder i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_code_unit      (i_code_unit),
        .i_first_of_text  (i_first_of_text),
        .i_last_of_text   (i_last_of_text),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_out_byte       (o_out_byte),
        .o_last_byte      (o_last_byte),
        .o_non_ascii_seen (o_non_ascii_seen)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // One code point to UTF-8; 5-byte form above 2^21, bits from 26 up lost.
    function automatic void emit_point(input logic [31:0] cp);
        int         extra;
        int         lim;
        logic [7:0] tag;
        logic [7:0] keep;
        logic [31:0] sh;
        if (cp < 32'h80) begin
            step_bytes.push_back('{cp[7:0], 1'b0, non_ascii});
        end else begin
            non_ascii = 1'b1;
            extra = 1;
            lim = 11;
            while (lim < 26 && cp >= (32'd1 << lim)) begin
                extra++;
                lim += 5;
            end
            tag = 8'hFF << (7 - extra);
            keep = (8'd1 << (6 - extra)) - 8'd1;
            sh = cp >> (6 * extra);
            step_bytes.push_back('{(sh[7:0] & keep) | tag, 1'b0, non_ascii});
            for (int k = extra; k > 0; k--) begin
                sh = cp >> (6 * (k - 1));
                step_bytes.push_back('{{2'b10, sh[5:0]}, 1'b0, non_ascii});
            end
        end
    endfunction

    function automatic void encode_unit(input logic [31:0] word, input logic first,
                                        input logic last);
        logic [15:0] u;
        logic [9:0]  hb;
        logic        joined;
        utf8_byte_t  tail;
        step_bytes.delete();
        joined = 1'b0;
        u = word[15:0];
        if (first) begin
            held_bits = '0;
            held_valid = 1'b0;
            non_ascii = 1'b0;
        end
        if (cfg_wide) begin
            held_bits = '0;
            held_valid = 1'b0;
            if (!(first && cfg_strip && word == 32'(BOM_UNIT)))
                emit_point(word);
        end else if (!(first && cfg_strip && u == BOM_UNIT)) begin
            if (held_valid) begin
                hb = held_bits;
                held_bits = '0;
                held_valid = 1'b0;
                if (u[15:10] == LOW_SURR_TAG) begin
                    emit_point(32'(SUPP_BASE) + {12'h0, hb, u[9:0]});
                    joined = 1'b1;
                end else begin
                    // orphaned high half goes out on its own
                    emit_point({16'h0, HIGH_SURR_TAG, hb});
                end
            end
            if (!joined) begin
                if (u[15:10] == HIGH_SURR_TAG && !last) begin
                    held_bits = u[9:0];
                    held_valid = 1'b1;
                end else begin
                    emit_point({16'h0, u});
                end
            end
        end
        if (step_bytes.size() != 0) begin
            tail = step_bytes.pop_back();
            tail.last = 1'b1;
            step_bytes.push_back(tail);
        end
        foreach (step_bytes[i])
            utf8_due.push_back(step_bytes[i]);
    endfunction

    task automatic note_mismatch(input string what, input int want, input int got);
        errors++;
        if (errors <= 10)
            $display("mismatch on %s: expected 0x%0h, got 0x%0h (byte %0d)",
                     what, want, got, bytes_done);
    endtask

    // monitor: results first, then the unit taken at this edge
    always @(posedge i_clk) begin
        utf8_byte_t want;
        if (!i_rst_n) begin
            unit_accepted = 1'b0;
            byte_accepted = 1'b0;
        end else if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("DONE: errors detected");
            $finish;
        end else begin
            cycles++;
            byte_accepted = o_out_valid && !i_out_stall;
            if (byte_accepted) begin
                bytes_done++;
                if (utf8_due.size() == 0) begin
                    note_mismatch("unexpected byte", -1, o_out_byte);
                end else begin
                    want = utf8_due.pop_front();
                    if (o_out_byte !== want.value)
                        note_mismatch("out_byte", want.value, o_out_byte);
                    if (o_last_byte !== want.last)
                        note_mismatch("last_byte", want.last, o_last_byte);
                    if (o_non_ascii_seen !== want.flag)
                        note_mismatch("non_ascii_seen", want.flag, o_non_ascii_seen);
                end
            end
            unit_accepted = i_in_valid && !o_in_stall;
            if (unit_accepted) begin
                units_done++;
                encode_unit(i_code_unit, i_first_of_text, i_last_of_text);
            end
        end
    end

    // driver: input items and output stall, both changed on the falling edge
    always @(negedge i_clk) begin
        logic       vld_next;
        unit_item_t nxt;
        if (i_rst_n) begin
            vld_next = i_in_valid && !unit_accepted;
            if (!vld_next) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (units_to_send.size() != 0) begin
                    nxt = units_to_send.pop_front();
                    i_code_unit <= nxt.cu;
                    i_first_of_text <= nxt.first;
                    i_last_of_text <= nxt.last;
                    vld_next = 1'b1;
                    gap_left = calm ? 0 : $urandom_range(0, 9);
                end
            end
            sending = vld_next;
            i_in_valid <= vld_next;
            if (byte_accepted)
                hold_left = calm ? 0 : $urandom_range(0, 9);
            if (hold_left > 0) begin
                i_out_stall <= 1'b1;
                hold_left--;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    task automatic add_unit(input logic [31:0] cu, input logic first, input logic last);
        units_to_send.push_back('{cu, first, last});
        queued++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == REG_UNIT_IS_32BIT)
            cfg_wide = val;
        else if (idx == REG_STRIP_BOM)
            cfg_strip = val;
    endtask

    // wait until every queued unit is in and every byte is out
    task automatic settle();
        while (units_to_send.size() != 0 || sending || utf8_due.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // a text of random content with first/last marks; may hold lone surrogates
    task automatic queue_text(input int n_units, input logic wide);
        int          k;
        logic [31:0] v;
        logic [15:0] top;
        k = 0;
        while (k < n_units) begin
            top = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'h0;
            case ($urandom_range(0, 9))
                0, 1: v = $urandom_range(0, 127);
                2: v = $urandom_range(128, 2047);
                3: v = $urandom_range(2048, 65535);
                4: v = 32'(BOM_UNIT);
                5, 6: begin
                    if (wide) begin
                        v = $urandom_range(65536, 2097151);
                    end else begin
                        add_unit({top, HIGH_SURR_TAG, 10'($urandom)}, k == 0, 1'b0);
                        k++;
                        v = {16'h0, LOW_SURR_TAG, 10'($urandom)};
                    end
                end
                7: v = wide ? $urandom_range(2097152, 67108863)
                            : {16'h0, HIGH_SURR_TAG, 10'($urandom)};
                8: v = wide ? $urandom : {16'h0, LOW_SURR_TAG, 10'($urandom)};
                default: v = $urandom;
            endcase
            if (k == 0 && $urandom_range(0, 3) == 0)
                v = 32'(BOM_UNIT);
            if (!wide && v[31:16] == 16'h0)
                v[31:16] = top;
            add_unit(v, k == 0, k >= n_units - 1);
            k++;
        end
    endtask

    // stray unit with random marks; biased to surrogates in 16-bit mode
    task automatic add_noise(input logic wide);
        logic [31:0] v;
        v = $urandom;
        if (!wide && $urandom_range(0, 1) == 1)
            v[15:11] = 5'b11011;
        add_unit(v, 1'($urandom), 1'($urandom));
    endtask

    initial begin
        int unsigned n_directed;
        int unsigned budget;
        int          p;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        write_reg(REG_UNIT_IS_32BIT, 1'b0);
        write_reg(REG_STRIP_BOM, 1'b1);

        // 16-bit units
        add_unit(32'h0000_FEFF, 1'b1, 1'b0);   // leading BOM, dropped
        add_unit(32'h0000_0000, 1'b0, 1'b0);
        add_unit(32'h0000_007F, 1'b0, 1'b0);
        add_unit(32'h0000_0080, 1'b0, 1'b0);
        add_unit(32'h0000_07FF, 1'b0, 1'b0);
        add_unit(32'h0000_0800, 1'b0, 1'b0);
        add_unit(32'h0000_FEFF, 1'b0, 1'b0);   // BOM mid-text, encoded
        add_unit(32'hFFFF_FFFF, 1'b0, 1'b0);   // upper half ignored
        add_unit(32'h0000_D83D, 1'b0, 1'b0);
        add_unit(32'h0000_DE00, 1'b0, 1'b0);
        add_unit(32'h0000_DBFF, 1'b0, 1'b0);
        add_unit(32'h0000_DFFF, 1'b0, 1'b0);
        add_unit(32'h0000_DC00, 1'b0, 1'b0);   // lone low half
        add_unit(32'h0000_D800, 1'b0, 1'b0);
        add_unit(32'h0000_0041, 1'b0, 1'b0);   // held high, then plain unit
        add_unit(32'h0000_D801, 1'b0, 1'b0);
        add_unit(32'h0000_D802, 1'b0, 1'b0);   // high after high
        add_unit(32'h0000_DC05, 1'b0, 1'b0);
        add_unit(32'h0000_DBC0, 1'b0, 1'b1);   // high on last unit, flushed
        add_unit(32'h0000_D800, 1'b1, 1'b0);
        add_unit(32'h0000_0041, 1'b1, 1'b0);   // new text drops the held half
        add_unit(32'h0000_D9AB, 1'b0, 1'b0);   // left held across the mode change
        settle();

        write_reg(REG_UNIT_IS_32BIT, 1'b1);
        add_unit(32'h0000_0041, 1'b0, 1'b0);
        add_unit(32'h0000_FEFF, 1'b1, 1'b0);
        add_unit(32'h001F_FFFF, 1'b0, 1'b0);
        add_unit(32'h0020_0000, 1'b0, 1'b0);
        add_unit(32'h03FF_FFFF, 1'b0, 1'b0);
        add_unit(32'hFFFF_FFFF, 1'b0, 1'b0);
        add_unit(32'h0000_D800, 1'b0, 1'b1);   // no joining in 32-bit mode
        settle();

        write_reg(REG_STRIP_BOM, 1'b0);
        add_unit(32'h0000_FEFF, 1'b1, 1'b1);
        settle();
        n_directed = queued;
        phases = 3;

        p = 0;
        while (queued < n_directed + RANDOM_UNITS) begin
            calm = ($urandom_range(0, 3) == 0);
            write_reg(REG_UNIT_IS_32BIT, p[0]);
            write_reg(REG_STRIP_BOM, p[1]);
            budget = queued + $urandom_range(30, 60);
            while (queued < budget) begin
                if ($urandom_range(0, 7) == 0)
                    add_noise(p[0]);
                else
                    queue_text($urandom_range(1, 12), p[0]);
            end
            settle();
            p++;
            phases++;
        end

        foreach (utf8_due[i])
            note_mismatch("missing byte", utf8_due[i].value, -1);
        $display("%0d code units over %0d setting phases, %0d UTF-8 bytes compared",
                 units_done, phases, bytes_done);
        $display("16- and 32-bit units, BOM strip on and off, surrogates and 5-byte forms");
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
